/* hdl/buddy_block_allocator_core_defines.svh */
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
// implication checked on every clock, quiet in reset
`define BBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication with the consequent checked on the next clock
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* hdl/bba_pkg.sv */
// shared constants for the buddy block allocator
`default_nettype none
package bba_pkg;
   localparam int POOL_BLOCKS = 256;
   localparam int LEVELS = $clog2(POOL_BLOCKS);
   localparam int NODE_COUNT = 2 * POOL_BLOCKS - 1;
   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int BLK_W = LEVELS;
   localparam int SIZE_W = LEVELS + 1;
   localparam int LVL_W = $clog2(LEVELS + 1);
   localparam logic [1:0] MARK_USED = 2'b01;
   localparam logic [1:0] MARK_SPLIT = 2'b10;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;
endpackage
`default_nettype wire

/* hdl/buddy_block_allocator_core.sv */
// buddy block allocator top level: node tree in one memory, walked by a sequencer
// One request at a time, taken when start is high and busy is low. After reset a
// clearing pass over all 511 nodes runs with busy high. Allocate walks the tree
// depth first. Each node visit reads, then evaluates and writes. Each step back
// to a parent goes through a return state. Checking and tidying a parent's split
// mark reads the left child, then the right child, then tidies. A full search may
// visit all 511 nodes. Free follows one root-to-leaf path and tidies on the way
// back. A zero-size or oversized allocate request answers in the cycle after it
// is accepted. The result beat is shown for one cycle on rsp_valid while busy is
// still high, and busy drops in the next cycle. The receiver cannot stall it.
`default_nettype none
module buddy_block_allocator_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic req_command,
   input  wire logic [8:0] req_request_blocks,
   input  wire logic [7:0] req_block_index,
   output logic      rsp_valid,
   output logic      rsp_success,
   output logic [7:0] rsp_start_block
);
   import bba_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READ  = 9'b000000100,
      ST_EVAL  = 9'b000001000,
      ST_RET   = 9'b000010000,
      ST_CHKL  = 9'b000100000,
      ST_CHKR  = 9'b001000000,
      ST_TIDY  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   logic [1:0] mem [NODE_COUNT];
   logic [1:0] rdata_ff;
   logic       we;
   logic [NODE_W-1:0] raddr;
   logic [1:0] wdata;

   state_type state_ff, state_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [LEVELS-1:0] path_ff, path_in;   // bit per level: 1 took right child
   logic cmd_ff, cmd_in;
   logic [8:0] want_ff, want_in;
   logic [BLK_W-1:0] idx_ff, idx_in;
   logic ok_ff, ok_in;
   logic [1:0] lmark_ff, lmark_in;
   logic [BLK_W-1:0] blk_ff, blk_in;

   always_ff @(posedge clock) begin
      if (we) mem[node_ff] <= wdata;
      rdata_ff <= mem[raddr];
   end

   logic [SIZE_W-1:0] size, half;
   logic [BLK_W-1:0] first;
   logic [NODE_W-1:0] parent, lchild, rchild;
   logic [LVL_W-1:0] lvl_dec;
   logic leaf;
   always_comb begin
      size = SIZE_W'(POOL_BLOCKS) >> lvl_ff;
      half = size >> 1;
      leaf = (lvl_ff == LVL_W'(LEVELS));
      lvl_dec = lvl_ff - LVL_W'(1);
      parent = (node_ff - NODE_W'(1)) >> 1;
      lchild = NODE_W'({node_ff, 1'b1});
      rchild = NODE_W'({node_ff, 1'b0}) + NODE_W'(2);
      first = '0;
      for (int i = 0; i < LEVELS; i++)
         if (i < int'(lvl_ff) && path_ff[i]) first = first | BLK_W'(POOL_BLOCKS >> (i + 1));
   end

   logic idxright;
   assign idxright = (idx_ff & BLK_W'(half)) != '0;

   always_comb begin
      state_in = state_ff; node_in = node_ff; lvl_in = lvl_ff; path_in = path_ff;
      cmd_in = cmd_ff; want_in = want_ff; idx_in = idx_ff;
      ok_in = ok_ff; lmark_in = lmark_ff; blk_in = blk_ff;
      we = 1'b0; wdata = 2'b00; raddr = node_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; wdata = 2'b00;
            node_in = node_ff + NODE_W'(1);
            if (node_ff == NODE_W'(NODE_COUNT - 1)) begin
               node_in = '0; state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_command; want_in = req_request_blocks;
               idx_in = req_block_index;
               node_in = '0; lvl_in = '0; path_in = '0; ok_in = 1'b0; blk_in = '0;
               if (req_command == CMD_ALLOC &&
                   (req_request_blocks == '0 ||
                    req_request_blocks > SIZE_W'(POOL_BLOCKS)))
                  state_in = ST_DONE;
               else state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (cmd_ff == CMD_ALLOC) begin
               if ((rdata_ff & MARK_USED) != '0 || want_ff > size) begin
                  ok_in = 1'b0; state_in = ST_RET;
               end else if (half < want_ff) begin
                  if ((rdata_ff & MARK_SPLIT) != '0) begin
                     ok_in = 1'b0; state_in = ST_RET;
                  end else begin
                     we = 1'b1; wdata = rdata_ff | MARK_USED;
                     ok_in = 1'b1; blk_in = first; state_in = ST_DONE;
                  end
               end else if (leaf) begin
                  ok_in = 1'b0; state_in = ST_RET;
               end else begin
                  we = 1'b1; wdata = rdata_ff | MARK_SPLIT;
                  node_in = lchild; lvl_in = lvl_ff + LVL_W'(1);
                  path_in[lvl_ff[LVL_W-2:0]] = 1'b0; state_in = ST_READ;
               end
            end else begin
               if ((rdata_ff & MARK_USED) != '0) begin
                  we = 1'b1; wdata = rdata_ff & ~MARK_USED;
                  ok_in = 1'b1; state_in = ST_RET;
               end else if ((rdata_ff & MARK_SPLIT) != '0 && !leaf) begin
                  node_in = idxright ? rchild : lchild;
                  lvl_in = lvl_ff + LVL_W'(1);
                  path_in[lvl_ff[LVL_W-2:0]] = idxright; state_in = ST_READ;
               end else begin
                  ok_in = 1'b0; state_in = ST_RET;
               end
            end
         end
         ST_RET: begin
            if (lvl_ff == '0) state_in = ST_DONE;
            else if (cmd_ff == CMD_ALLOC && !path_ff[lvl_dec[LVL_W-2:0]]) begin
               // left branch failed, try the right sibling
               node_in = node_ff + NODE_W'(1);
               path_in[lvl_dec[LVL_W-2:0]] = 1'b1; state_in = ST_READ;
            end else begin
               node_in = parent; lvl_in = lvl_dec; state_in = ST_CHKL;
            end
         end
         ST_CHKL: begin
            raddr = lchild; state_in = ST_CHKR;
         end
         ST_CHKR: begin
            raddr = rchild; lmark_in = rdata_ff; state_in = ST_TIDY;
         end
         ST_TIDY: begin
            // parent only carries the split mark here
            if (lmark_ff == 2'b00 && rdata_ff == 2'b00) begin
               we = 1'b1; wdata = 2'b00;
            end
            state_in = ST_RET;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; node_ff <= '0; lvl_ff <= '0; path_ff <= '0;
         cmd_ff <= CMD_ALLOC; want_ff <= '0; idx_ff <= '0;
         ok_ff <= 1'b0; lmark_ff <= 2'b00; blk_ff <= '0;
      end else begin
         state_ff <= state_in; node_ff <= node_in; lvl_ff <= lvl_in;
         path_ff <= path_in; cmd_ff <= cmd_in; want_ff <= want_in;
         idx_ff <= idx_in; ok_ff <= ok_in; lmark_ff <= lmark_in;
         blk_ff <= blk_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_success = ok_ff;
   assign rsp_start_block = blk_ff;
endmodule
`default_nettype wire

/* hdl/bba_checker.sv */
// port-level checker for the buddy block allocator, bound to the top level
`default_nettype none
`include "buddy_block_allocator_core_defines.svh"
module bba_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_success,
   input wire logic [7:0] rsp_start_block
);
   `BBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `BBA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && !rsp_success, rsp_start_block == 8'd0)
   `BBA_ASSERT_NEXT(a_one_beat, clock, reset, rsp_valid, !rsp_valid)
endmodule
bind buddy_block_allocator_core bba_checker u_chk (.*);
`default_nettype wire

/* tb/sv/buddy_block_allocator_checker.sv */
// checker for the buddy block allocator: tree predictor and result compare
`timescale 1ns / 100ps
`default_nettype none
module buddy_block_allocator_checker
   import bba_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       busy,
   input  wire logic       req_command,
   input  wire logic [8:0] req_request_blocks,
   input  wire logic [7:0] req_block_index,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_success,
   input  wire logic [7:0] rsp_start_block,
   output int              mismatch_count,
   output int              pending_count
);
   typedef struct packed {
      logic       success;
      logic [7:0] start_block;
   } grant_type;

   logic [1:0] tree_marks [NODE_COUNT];
   grant_type grants_due [$];

   function automatic bit kids_clear(int node);
      if (2 * node + 2 >= NODE_COUNT) begin
         return 1;
      end
      return tree_marks[2 * node + 1] == 2'b00 && tree_marks[2 * node + 2] == 2'b00;
   endfunction

   function automatic bit claim_run(int want, int node, int first, int size, ref int base);
      int half;
      half = size / 2;
      if (node >= NODE_COUNT) begin
         return 0;
      end
      if ((tree_marks[node] & MARK_USED) != 0 || want > size) begin
         return 0;
      end
      if (half < want) begin
         if ((tree_marks[node] & MARK_SPLIT) != 0) begin
            return 0;
         end
         tree_marks[node] |= MARK_USED;
         base = first;
         return 1;
      end
      if (2 * node + 2 >= NODE_COUNT) begin
         return 0;
      end
      tree_marks[node] |= MARK_SPLIT;
      if (claim_run(want, 2 * node + 1, first, half, base)) begin
         return 1;
      end
      if (claim_run(want, 2 * node + 2, first + half, half, base)) begin
         return 1;
      end
      if (kids_clear(node)) begin
         tree_marks[node] &= ~MARK_SPLIT;
      end
      return 0;
   endfunction

   function automatic bit release_run(int blk, int node, int first, int size);
      int half;
      bit done;
      half = size / 2;
      done = 0;
      if (node >= NODE_COUNT) begin
         return 0;
      end
      if ((tree_marks[node] & MARK_USED) != 0) begin
         if (first <= blk && blk < first + size) begin
            tree_marks[node] &= ~MARK_USED;
            done = 1;
         end
      end else if ((tree_marks[node] & MARK_SPLIT) != 0) begin
         if (2 * node + 2 >= NODE_COUNT) begin
            return 0;
         end
         if (blk < first + half) begin
            done = release_run(blk, 2 * node + 1, first, half);
         end else begin
            done = release_run(blk, 2 * node + 2, first + half, half);
         end
         if (kids_clear(node)) begin
            tree_marks[node] &= ~MARK_SPLIT;
         end
      end
      return done;
   endfunction

   function automatic grant_type predict_grant(logic cmd, int want, int blk);
      grant_type g;
      int base;
      base = 0;
      g = '0;
      if (cmd == CMD_ALLOC) begin
         if (want != 0) begin
            g.success = claim_run(want, 0, 0, POOL_BLOCKS, base);
         end
         g.start_block = g.success ? base[7:0] : 8'd0;
      end else begin
         g.success = release_run(blk, 0, 0, POOL_BLOCKS);
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want_g;
      if (reset) begin
         foreach (tree_marks[i]) tree_marks[i] = 2'b00;
         grants_due.delete();
         mismatch_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected beat: success=%0b start=%0d", rsp_success,
                           rsp_start_block);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want_g = grants_due.pop_front();
               if (want_g.success !== rsp_success ||
                   want_g.start_block !== rsp_start_block) begin
                  if (mismatch_count < 10) begin
                     $display("beat mismatch: expected success=%0b start=%0d, got %0b %0d",
                              want_g.success, want_g.start_block, rsp_success,
                              rsp_start_block);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (start && !busy) begin
            grants_due.push_back(predict_grant(req_command, req_request_blocks,
                                               req_block_index));
         end
         pending_count <= grants_due.size();
      end
   end
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// testbench top: clock, reset, allocate and free stimulus, verdict
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import bba_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       req_command = CMD_ALLOC;
   logic [8:0] req_request_blocks = '0;
   logic [7:0] req_block_index = '0;
   wire logic       busy;
   wire logic       rsp_valid;
   wire logic       rsp_success;
   wire logic [7:0] rsp_start_block;
   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int live_starts [$];

   always #2 clock = ~clock;

   buddy_block_allocator_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_request_blocks(req_request_blocks),
      .req_block_index(req_block_index), .rsp_valid(rsp_valid),
      .rsp_success(rsp_success), .rsp_start_block(rsp_start_block)
   );

   buddy_block_allocator_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_request_blocks(req_request_blocks),
      .req_block_index(req_block_index), .rsp_valid(rsp_valid),
      .rsp_success(rsp_success), .rsp_start_block(rsp_start_block),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // track allocations so frees mostly hit live blocks
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_success && req_command == CMD_ALLOC)
         live_starts.push_back(rsp_start_block);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 20000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_beat(logic cmd, int want, int blk);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clock);
      start <= 1;
      req_command <= cmd;
      req_request_blocks <= want[8:0];
      req_block_index <= blk[7:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 0;
      // wait for the result before a new start so the command stays stable
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic random_beat();
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         k = $urandom_range(0, 8);
         send_beat(CMD_ALLOC, $urandom_range(1 << k >> 1, 1 << k) | 1'b0 + (k == 0), 0);
      end else if (pick < 85 && live_starts.size() > 0) begin
         k = $urandom_range(0, live_starts.size() - 1);
         send_beat(CMD_FREE, $urandom_range(0, 511), live_starts[k] +
                   ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3)));
         live_starts.delete(k);
      end else if (pick < 92) begin
         send_beat(CMD_FREE, $urandom_range(0, 511), $urandom_range(0, 255));
      end else begin
         send_beat(CMD_ALLOC, $urandom_range(0, 511), $urandom_range(0, 255));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_beat(CMD_ALLOC, 0, 255);
      send_beat(CMD_ALLOC, 257, 0);
      send_beat(CMD_ALLOC, 511, 0);
      send_beat(CMD_FREE, 0, 0);
      send_beat(CMD_ALLOC, 256, 0);
      send_beat(CMD_ALLOC, 1, 0);
      send_beat(CMD_FREE, 0, 200);
      send_beat(CMD_FREE, 0, 0);
      send_beat(CMD_ALLOC, 1, 0);
      send_beat(CMD_ALLOC, 1, 0);
      send_beat(CMD_ALLOC, 2, 0);
      send_beat(CMD_ALLOC, 3, 0);
      send_beat(CMD_ALLOC, 128, 0);
      send_beat(CMD_ALLOC, 129, 0);
      send_beat(CMD_ALLOC, 64, 0);
      send_beat(CMD_FREE, 0, 1);
      send_beat(CMD_FREE, 0, 0);
      send_beat(CMD_FREE, 0, 130);
      send_beat(CMD_FREE, 0, 255);
      send_beat(CMD_FREE, 0, 2);
      send_beat(CMD_FREE, 0, 4);
      send_beat(CMD_FREE, 0, 5);
      send_beat(CMD_ALLOC, 256, 0);
      send_beat(CMD_FREE, 0, 128);
      repeat (1150) random_beat();
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire
